@@ src/koala_style_permutation_257_macros.svh @@
//------------------------------------------------------------------------------
// koala_style_permutation_257_macros.svh
// Assertion macros shared by the permutation checker.
//------------------------------------------------------------------------------
`ifndef KOALA_STYLE_PERMUTATION_257_MACROS_SVH
`define KOALA_STYLE_PERMUTATION_257_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define KP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("koala permutation check failed");

// Next-cycle implication, disabled while reset is asserted
`define KP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("koala permutation check failed");

// Next-cycle implication that also holds across reset
`define KP_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("koala permutation check failed");

`endif

@@ src/kp_pkg.sv @@
//------------------------------------------------------------------------------
// kp_pkg
// Shared constants, types and the round function of the 257-bit permutation.
//------------------------------------------------------------------------------
package kp_pkg;

    localparam int KP_NBITS      = 257;
    localparam int KP_WORD_W     = 64;
    localparam int KP_NWORDS     = 5;
    localparam int KP_LOAD_BITS  = KP_WORD_W * (KP_NWORDS - 1);
    localparam int KP_PAD_W      = KP_WORD_W * KP_NWORDS;
    localparam int KP_ROUND_W    = 6;
    localparam int KP_CNT_W      = 3;
    localparam int KP_MAX_ROUNDS = 63;
    localparam int KP_QDEPTH     = 2;
    localparam int KP_QPTR_W     = 1;
    localparam int KP_QCNT_W     = 2;

    localparam logic [KP_ROUND_W-1:0] KP_ROUNDS_RESET = 6'd8;
    localparam logic [KP_CNT_W-1:0]   KP_LAST_WORD    = KP_CNT_W'(KP_NWORDS - 1);

    // Rounds that skip the constant flip: 1, 4 and 5
    localparam logic [63:0] KP_RC_SKIP = 64'h0000_0000_0000_0032;

    // One job handed from the loader to the round engine
    typedef struct packed {
        logic [KP_NBITS-1:0]   bits;
        logic [KP_ROUND_W-1:0] rounds;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_EMIT
    } t_back_state;

    // One full round: shuffle, mix, constant, chi
    function automatic logic [KP_NBITS-1:0] f_round(input logic [KP_NBITS-1:0] a,
                                                    input logic [KP_ROUND_W-1:0] r);
        logic [KP_NBITS-1:0] b;
        logic [KP_NBITS-1:0] c;
        logic [KP_NBITS-1:0] o;
        for (int i = 0; i < KP_NBITS; i++) begin
            b[i] = a[(121 * i) % KP_NBITS];
        end
        for (int i = 0; i < KP_NBITS; i++) begin
            c[i] = b[i] ^ b[(i + 3) % KP_NBITS] ^ b[(i + 10) % KP_NBITS];
        end
        if (!KP_RC_SKIP[r]) begin
            c[0] = ~c[0];
        end
        for (int i = 0; i < KP_NBITS; i++) begin
            o[i] = c[i] ^ c[(i + 2) % KP_NBITS] ^ (c[(i + 1) % KP_NBITS] & c[(i + 2) % KP_NBITS]);
        end
        return o;
    endfunction

endpackage

@@ src/kp_front.sv @@
//------------------------------------------------------------------------------
// kp_front
// Word loader: assembles five input words into a job and queues it.
//------------------------------------------------------------------------------
module kp_front #(
    parameter int MAX_ROUNDS = kp_pkg::KP_MAX_ROUNDS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [kp_pkg::KP_WORD_W-1:0]    i_state_word,
    input  logic                            i_cfg_we,
    input  logic [kp_pkg::KP_ROUND_W-1:0]   i_cfg_wdata,
    output logic                            o_push,
    output kp_pkg::t_job                    o_job
);
    import kp_pkg::*;

    localparam logic [7:0] MaxRounds = 8'(MAX_ROUNDS);

    logic [KP_CNT_W-1:0]     r_words;
    logic [KP_CNT_W-1:0]     n_words;
    logic [KP_LOAD_BITS-1:0] r_bits;
    logic [KP_LOAD_BITS-1:0] n_bits;
    logic [KP_ROUND_W-1:0]   r_round_count;
    logic [KP_ROUND_W-1:0]   sat_rounds;
    logic                    is_fifth;

    // Classify the transfer: store a word or close the job
    assign is_fifth = (r_words == KP_LAST_WORD);
    assign o_push   = i_accept && is_fifth;

    // Saturate the configured count to the engine limit
    assign sat_rounds = ({2'b00, r_round_count} > MaxRounds) ? MaxRounds[KP_ROUND_W-1:0]
                                                             : r_round_count;

    assign o_job.bits   = {i_state_word[0], r_bits};
    assign o_job.rounds = sat_rounds;

    // Advance the word count and place the word
    always_comb begin
        n_words = r_words;
        n_bits  = r_bits;
        if (i_accept) begin
            if (is_fifth) begin
                n_words = '0;
            end else begin
                n_words = r_words + 1'b1;
                for (int k = 0; k < KP_NWORDS - 1; k++) begin
                    if (r_words[1:0] == 2'(k)) begin
                        n_bits[k*KP_WORD_W +: KP_WORD_W] = i_state_word;
                    end
                end
            end
        end
    end

    // Hold control state and the round count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words       <= '0;
            r_round_count <= KP_ROUNDS_RESET;
        end else begin
            r_words <= n_words;
            if (i_cfg_we) begin
                r_round_count <= i_cfg_wdata;
            end
        end
    end

    // Hold partial state words
    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
    end

endmodule

@@ src/kp_queue.sv @@
//------------------------------------------------------------------------------
// kp_queue
// Short job queue between the loader and the round engine.
//------------------------------------------------------------------------------
module kp_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  kp_pkg::t_job i_job,
    input  logic         i_pop,
    output kp_pkg::t_job o_head,
    output logic         o_full,
    output logic         o_empty
);
    import kp_pkg::*;

    t_job                 r_mem [KP_QDEPTH];
    logic [KP_QPTR_W-1:0] r_wr_ptr;
    logic [KP_QPTR_W-1:0] r_rd_ptr;
    logic [KP_QCNT_W-1:0] r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == KP_QCNT_W'(KP_QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the incoming job
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ src/kp_back.sv @@
//------------------------------------------------------------------------------
// kp_back
// Round engine: one round per cycle, then five output words in a burst.
//------------------------------------------------------------------------------
module kp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  kp_pkg::t_job                  i_job,
    output logic                          o_pop,
    output logic                          o_result_strobe,
    output logic [kp_pkg::KP_WORD_W-1:0]  o_out_word,
    output logic                          o_last_word
);
    import kp_pkg::*;

    t_back_state           r_state;
    t_back_state           n_state;
    logic [KP_NBITS-1:0]   r_bits;
    logic [KP_ROUND_W-1:0] r_round;
    logic [KP_ROUND_W-1:0] r_rounds;
    logic [KP_CNT_W-1:0]   r_word_idx;
    logic [KP_WORD_W-1:0]  r_out_word;
    logic                  r_out_valid;
    logic                  r_out_last;
    logic                  n_out_valid;
    logic [KP_PAD_W-1:0]   padded;
    logic                  last_round;
    logic                  last_emit;

    assign padded     = {{(KP_PAD_W - KP_NBITS){1'b0}}, r_bits};
    assign last_round = (r_round == r_rounds - 1'b1);
    assign last_emit  = (r_word_idx == KP_LAST_WORD);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_job.rounds == '0) ? ST_EMIT : ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (last_round) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (last_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop       = 1'b0;
        n_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_pop = !i_empty;
            ST_ROUND: o_pop = 1'b0;
            ST_EMIT:  n_out_valid = 1'b1;
            default:  o_pop = 1'b0;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Load, iterate rounds, and shift out words
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bits     <= i_job.bits;
            r_rounds   <= i_job.rounds;
            r_round    <= '0;
            r_word_idx <= '0;
        end else if (r_state == ST_ROUND) begin
            r_bits  <= f_round(r_bits, r_round);
            r_round <= r_round + 1'b1;
        end else if (r_state == ST_EMIT) begin
            r_out_word <= padded[r_word_idx*KP_WORD_W +: KP_WORD_W];
            r_out_last <= last_emit;
            r_word_idx <= r_word_idx + 1'b1;
        end
    end

    assign o_result_strobe = r_out_valid;
    assign o_out_word      = r_out_word;
    assign o_last_word     = r_out_valid && r_out_last;

endmodule

@@ src/koala_style_permutation_257.sv @@
//------------------------------------------------------------------------------
// koala_style_permutation_257
// Koala-style permutation of a 257-bit state loaded and returned in 64-bit words.
//------------------------------------------------------------------------------
// The fifth word's transfer pushes a job into the queue; the idle engine pops it
// and runs one round per cycle, n being the round count (capped at MAX_ROUNDS),
// then emits the result words from a register. The engine takes no new job until
// its last word is out; loading of the next five words overlaps through a two-entry job queue.
// Reset: synchronous, active low; clears word count, queue and engine, sets the
// round count to 8. Results are strobed and cannot be stalled by the receiver.
module koala_style_permutation_257 #(
    parameter int MAX_ROUNDS = kp_pkg::KP_MAX_ROUNDS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [kp_pkg::KP_WORD_W-1:0]    i_state_word,
    input  logic                            i_cfg_we,
    input  logic [kp_pkg::KP_ROUND_W-1:0]   i_cfg_wdata,
    output logic                            o_result_strobe,
    output logic [kp_pkg::KP_WORD_W-1:0]    o_out_word,
    output logic                            o_last_word
);
    import kp_pkg::*;

    t_job job_in;
    t_job job_head;
    logic accept;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    // Refuse transfers while the queue is full or in reset
    assign busy   = q_full || !i_rst_n;
    assign accept = start && !busy;

    kp_front #(
        .MAX_ROUNDS (MAX_ROUNDS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_state_word (i_state_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_push       (push),
        .o_job        (job_in)
    );

    kp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_head  (job_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    kp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_job           (job_head),
        .o_pop           (pop),
        .o_result_strobe (o_result_strobe),
        .o_out_word      (o_out_word),
        .o_last_word     (o_last_word)
    );

endmodule

@@ src/kp_checker.sv @@
//------------------------------------------------------------------------------
// kp_checker
// Port-level checks on the result burst of the permutation block.
//------------------------------------------------------------------------------
`include "koala_style_permutation_257_macros.svh"

module kp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_result_strobe,
    input logic [63:0] o_out_word,
    input logic        o_last_word
);

    // Last marker only with a strobe
    `KP_ASSERT_NOW(a_last_has_strobe, i_clk, i_rst_n, o_last_word, o_result_strobe)

    // Final word carries only state bit 256
    `KP_ASSERT_NOW(a_last_upper_zero, i_clk, i_rst_n, o_result_strobe && o_last_word, o_out_word[63:1] == 63'd0)

    // Words of one result come back to back
    `KP_ASSERT_NEXT(a_burst_cont, i_clk, i_rst_n, o_result_strobe && !o_last_word, o_result_strobe)

    // A burst ends after its last word
    `KP_ASSERT_NEXT(a_burst_end, i_clk, i_rst_n, o_result_strobe && o_last_word, !o_result_strobe)

    // Reset leaves no result pending
    `KP_ASSERT_ALWAYS_NEXT(a_reset_clear, i_clk, !i_rst_n, !o_result_strobe)

endmodule

bind koala_style_permutation_257 kp_checker u_kp_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// testbench
// Drives 64-bit state words into the 257-bit permutation, rebuilds each
// permuted state in a bit-level predictor and checks every strobed output word
// and its last flag in order. A short table of hand-picked states comes first,
// then random states over several round counts, with random sender gaps.
//------------------------------------------------------------------------------
module testbench;

    import kp_pkg::*;

    localparam int WORD_W       = KP_WORD_W;
    localparam int STATE_BITS   = KP_NBITS;
    localparam int WORDS_PER    = KP_NWORDS;
    localparam int ROUND_CAP    = KP_MAX_ROUNDS;
    localparam int SETTLE_CYC   = KP_MAX_ROUNDS + 8;
    localparam int TARGET_ITEMS = 440;
    localparam int LIMIT_CYC    = 400000;
    localparam int PRINT_CAP    = 30;
    localparam int DIRECTED_N   = 5;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_out_word;

    // One directed state: round count, five input words, optional typed result
    typedef struct packed {
        logic [KP_ROUND_W-1:0]        rounds;
        logic [0:4][WORD_W-1:0]       words;
        logic                         typed;
        logic [0:4][WORD_W-1:0]       known;
    } t_state_row;

    logic                  i_clk;
    logic                  i_rst_n      = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic [WORD_W-1:0]     i_state_word = '0;
    logic                  i_cfg_we     = 1'b0;
    logic [KP_ROUND_W-1:0] i_cfg_wdata  = '0;
    logic                  o_result_strobe;
    logic [WORD_W-1:0]     o_out_word;
    logic                  o_last_word;

    koala_style_permutation_257 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_state_word    (i_state_word),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_result_strobe (o_result_strobe),
        .o_out_word      (o_out_word),
        .o_last_word     (o_last_word)
    );

    // Predictor state
    logic [STATE_BITS-1:0] state_bits   = '0;
    int                    words_held   = 0;
    logic [KP_ROUND_W-1:0] round_setting = KP_ROUNDS_RESET;

    t_out_word   pending_words[$];
    t_out_word   head_word;
    int unsigned cycle_count    = 0;
    int          mismatch_count = 0;
    int          items_sent     = 0;
    bit          sender_idles   = 1'b1;
    t_state_row  state_table [DIRECTED_N];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Stop a hung run
    initial begin
        wait (cycle_count >= LIMIT_CYC);
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // One round: shuffle, mix by rotation, round constant, chi by rotation
    function automatic logic [STATE_BITS-1:0] permute_round(
        input logic [STATE_BITS-1:0] s,
        input int                    rnd
    );
        logic [STATE_BITS-1:0] shuf;
        logic [STATE_BITS-1:0] mix;
        logic [STATE_BITS-1:0] nxt1;
        logic [STATE_BITS-1:0] nxt2;
        int k;
        for (k = 0; k < STATE_BITS; k++) begin
            shuf[k] = s[(121 * k) % STATE_BITS];
        end
        mix = shuf ^ {shuf[2:0], shuf[STATE_BITS-1:3]} ^ {shuf[9:0], shuf[STATE_BITS-1:10]};
        // rounds 1, 4 and 5 carry no constant
        if (rnd != 1 && rnd != 4 && rnd != 5) begin
            mix[0] = ~mix[0];
        end
        nxt1 = {mix[0], mix[STATE_BITS-1:1]};
        nxt2 = {mix[1:0], mix[STATE_BITS-1:2]};
        return mix ^ nxt2 ^ (nxt1 & nxt2);
    endfunction

    // Fold one transferred word into the predictor; the fifth word yields a result
    task automatic absorb_state_word(
        input logic [WORD_W-1:0]  w,
        input logic               typed,
        input logic [0:4][WORD_W-1:0] known
    );
        t_out_word e;
        int n;
        int r;
        int k;
        if (words_held < WORDS_PER - 1) begin
            state_bits[words_held * WORD_W +: WORD_W] = w;
            words_held++;
        end else begin
            state_bits[STATE_BITS-1] = w[0];
            words_held = 0;
            n = (round_setting > ROUND_CAP) ? ROUND_CAP : int'(round_setting);
            for (r = 0; r < n; r++) begin
                state_bits = permute_round(state_bits, r);
            end
            for (k = 0; k < WORDS_PER; k++) begin
                if (k < WORDS_PER - 1) begin
                    e.word = state_bits[k * WORD_W +: WORD_W];
                end else begin
                    e.word = {{(WORD_W-1){1'b0}}, state_bits[STATE_BITS-1]};
                end
                if (typed) begin
                    e.word = known[k];
                end
                e.last = (k == WORDS_PER - 1);
                pending_words.push_back(e);
            end
        end
    endtask

    // Present one word, hold it until the transfer, then update the predictor
    task automatic send_word(
        input logic [WORD_W-1:0]      w,
        input logic                   typed,
        input logic [0:4][WORD_W-1:0] known
    );
        int gap;
        gap = sender_idles ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_state_word <= w;
        do @(posedge i_clk); while (busy);
        absorb_state_word(w, typed, known);
        items_sent++;
    endtask

    // Drop start, wait for every pending word, then let the engine settle
    task automatic wait_quiet();
        start <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_round_count(input logic [KP_ROUND_W-1:0] n);
        i_cfg_wdata <= n;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        round_setting = n;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return {{(WORD_W-1){1'b0}}, 1'b1} << $urandom_range(0, WORD_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [KP_ROUND_W-1:0] pick_rounds();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return KP_ROUND_W'(ROUND_CAP);
            default: return KP_ROUND_W'($urandom_range(1, 12));
        endcase
    endfunction

    // Check each strobed word against the oldest pending one
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", o_out_word));
            end else begin
                head_word = pending_words.pop_front();
                if (o_out_word !== head_word.word) begin
                    report_mismatch($sformatf("out_word %h, want %h",
                                              o_out_word, head_word.word));
                end
                if (o_last_word !== head_word.last) begin
                    report_mismatch($sformatf("last_word %b, want %b",
                                              o_last_word, head_word.last));
                end
            end
        end
    end

    initial begin
        logic [0:4][WORD_W-1:0] no_known;
        logic [0:4][WORD_W-1:0] words;
        logic [KP_ROUND_W-1:0]  n;
        int  row;
        int  k;
        int  phase;
        int  set_no;
        int  sets;
        int  split;

        no_known = '0;
        // reset value, pass-through extremes, the top count, the skipped constants
        state_table[0] = '{KP_ROUNDS_RESET,
                           '{64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                             64'h0, 64'hffff_ffff_ffff_ffff, 64'h1},
                           1'b0, '0};
        state_table[1] = '{6'd0, '0, 1'b1, '0};
        state_table[2] = '{6'd0,
                           '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                             64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                             64'hffff_ffff_ffff_ffff},
                           1'b1,
                           '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                             64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                             64'h1}};
        state_table[3] = '{KP_ROUND_W'(ROUND_CAP),
                           '{64'ha5a5_a5a5_a5a5_a5a5, 64'h5a5a_5a5a_5a5a_5a5a,
                             64'h8000_0000_0000_0001, 64'h0000_0001_0000_0000, 64'h1},
                           1'b0, '0};
        state_table[4] = '{6'd6,
                           '{64'hdead_beef_cafe_f00d, 64'h0, 64'h0,
                             64'h7fff_ffff_ffff_fffe, 64'hffff_ffff_ffff_fffe},
                           1'b0, '0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed states
        sender_idles = 1'b0;
        for (row = 0; row < DIRECTED_N; row++) begin
            if (state_table[row].rounds != round_setting) begin
                wait_quiet();
                write_round_count(state_table[row].rounds);
            end
            for (k = 0; k < WORDS_PER; k++) begin
                send_word(state_table[row].words[k], state_table[row].typed,
                          state_table[row].known);
            end
            sender_idles = 1'b1;
        end

        // Random states, one round count per phase
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            wait_quiet();
            n = pick_rounds();
            write_round_count(n);
            sender_idles = ($urandom_range(0, 3) != 0);
            sets = $urandom_range(3, 8);
            for (set_no = 0; set_no < sets; set_no++) begin
                for (k = 0; k < WORDS_PER; k++) begin
                    words[k] = pick_word();
                end
                // Change the round count midway through a load now and then
                split = 0;
                if ((phase == 0 && set_no == 0) || $urandom_range(0, 7) == 0) begin
                    split = $urandom_range(1, WORDS_PER - 1);
                end
                for (k = 0; k < WORDS_PER; k++) begin
                    if (split != 0 && k == split) begin
                        wait_quiet();
                        write_round_count(pick_rounds());
                    end
                    send_word(words[k], 1'b0, no_known);
                end
            end
            phase++;
        end

        wait_quiet();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/kp_pkg.sv
src/kp_front.sv
src/kp_queue.sv
src/kp_back.sv
src/koala_style_permutation_257.sv
src/kp_checker.sv
tb/testbench.sv
